// File: rtl/core/mpq_pkg.sv
// Package for the max-scan priority queue: widths, capacity default,
// operation codes and result status codes. No dependencies.
package mpq_pkg;

   localparam int unsigned CAPACITY = 1024;
   localparam int unsigned VALUE_W  = 32;
   localparam int unsigned PRIO_W   = 16;
   localparam int unsigned ENTRY_W  = VALUE_W + PRIO_W;

   typedef enum logic [1:0] {
      MODE_ENQUEUE = 2'd0,
      MODE_DEQUEUE = 2'd1,
      MODE_MODIFY  = 2'd2,
      MODE_CLEAR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_DONE      = 2'd0,
      STATUS_FULL      = 2'd1,
      STATUS_EMPTY     = 2'd2,
      STATUS_NOT_FOUND = 2'd3
   } status_type;

endpackage

// File: rtl/core/mpq_ram.sv
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module mpq_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 16,
   localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/max_scan_priority_queue.sv
// Top level of the max-scan priority queue: control sequencer around one
// entry RAM. Depends on mpq_pkg and mpq_ram.
//
//   channel   direction  handshake            payload
//   req_      in         req_valid/req_stall  mode, item_value, item_priority
//   rsp_      out        rsp_valid/rsp_stall  status, count, front_value, empty_res
//
// Enqueue, clear, a refused enqueue and a dequeue on an empty queue go from
// acceptance straight to FINISH and the result register. Dequeue shifts the
// entries behind the front down and then rescans the rest for the new front;
// modify searches for its match and then rescans. The single read port of the
// entry RAM is walked one entry per cycle.
// Reset is synchronous; it empties the queue at once, without touching the
// RAM, whose entries are only read after they were written.
// One transaction is worked on at a time; a new request is taken as soon as
// the previous one has moved into the result register, even while that
// result is still stalled.
module max_scan_priority_queue #(
   parameter int unsigned CAPACITY = mpq_pkg::CAPACITY,
   localparam int unsigned CNT_W = $clog2(CAPACITY + 1)
) (
   input  logic                               clock,
   input  logic                               reset,
   // Request channel.
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [1:0]                         req_mode,
   input  logic signed [mpq_pkg::VALUE_W-1:0] req_item_value,
   input  logic signed [mpq_pkg::PRIO_W-1:0]  req_item_priority,
   // Response channel.
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic [1:0]                         rsp_status,
   output logic [CNT_W-1:0]                   rsp_count,
   output logic signed [mpq_pkg::VALUE_W-1:0] rsp_front_value,
   output logic                               rsp_empty_res
);

   localparam int unsigned ADDR_W  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int unsigned VALUE_W = mpq_pkg::VALUE_W;
   localparam int unsigned PRIO_W  = mpq_pkg::PRIO_W;
   localparam int unsigned ENTRY_W = mpq_pkg::ENTRY_W;

   // IDLE waits for a request. SEARCH walks the entries for the first one
   // holding the value. SHIFT moves the entries behind the removed one down
   // by one place. SCAN walks all entries to find the first maximum.
   // FINISH hands the result to the output register.
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_SHIFT,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type                  state_ff, state_in;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [CNT_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic                       pvld_ff, pvld_in;
   logic [ADDR_W-1:0]          paddr_ff, paddr_in;
   logic [ADDR_W-1:0]          front_idx_ff, front_idx_in;
   logic signed [PRIO_W-1:0]   front_prio_ff, front_prio_in;
   logic [VALUE_W-1:0]         front_val_ff, front_val_in;
   logic [VALUE_W-1:0]         val_ff, val_in;
   logic [PRIO_W-1:0]          key_ff, key_in;
   mpq_pkg::status_type        status_ff, status_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]           rsp_count_ff, rsp_count_in;
   logic [VALUE_W-1:0]         rsp_front_ff, rsp_front_in;
   logic                       rsp_empty_ff, rsp_empty_in;

   logic                       wr_en;
   logic [ADDR_W-1:0]          wr_addr;
   logic [ENTRY_W-1:0]         wr_data;
   logic [ENTRY_W-1:0]         rd_data;
   logic [VALUE_W-1:0]         rd_val;
   logic signed [PRIO_W-1:0]   rd_prio;
   logic                       walking;
   logic                       issue;

   // Each entry is stored as {value, priority}.
   mpq_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (CAPACITY)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_ptr_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   assign rd_val  = rd_data[ENTRY_W-1:PRIO_W];
   assign rd_prio = $signed(rd_data[PRIO_W-1:0]);

   // The read pointer always addresses the RAM. A read counts only while a
   // walk is under way and the pointer is still inside the occupied part;
   // its data arrives in the next cycle, tagged by pvld_ff and paddr_ff.
   assign walking = (state_ff == ST_SEARCH) || (state_ff == ST_SHIFT) ||
                    (state_ff == ST_SCAN);
   assign issue   = walking && (rd_ptr_ff < count_ff);

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rd_ptr_in     = rd_ptr_ff;
      pvld_in       = issue;
      paddr_in      = rd_ptr_ff[ADDR_W-1:0];
      front_idx_in  = front_idx_ff;
      front_prio_in = front_prio_ff;
      front_val_in  = front_val_ff;
      val_in        = val_ff;
      key_in        = key_ff;
      status_in     = status_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_front_in  = rsp_front_ff;
      rsp_empty_in  = rsp_empty_ff;
      wr_en         = 1'b0;
      wr_addr       = '0;
      wr_data       = '0;

      if (issue) begin
         rd_ptr_in = rd_ptr_ff + CNT_W'(1);
      end

      // The result register empties when the receiver takes the transaction.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               val_in    = req_item_value;
               key_in    = req_item_priority;
               status_in = mpq_pkg::STATUS_DONE;
               case (req_mode)
                  mpq_pkg::MODE_ENQUEUE: begin
                     state_in = ST_FINISH;
                     if (count_ff == CNT_W'(CAPACITY)) begin
                        status_in = mpq_pkg::STATUS_FULL;
                     end else begin
                        wr_en    = 1'b1;
                        wr_addr  = count_ff[ADDR_W-1:0];
                        wr_data  = {req_item_value, req_item_priority};
                        count_in = count_ff + CNT_W'(1);
                        // Appending never disturbs the front unless the new
                        // priority is strictly higher, since ties keep the
                        // earlier entry.
                        if ((count_ff == '0) || (req_item_priority > front_prio_ff)) begin
                           front_idx_in  = count_ff[ADDR_W-1:0];
                           front_prio_in = req_item_priority;
                           front_val_in  = req_item_value;
                        end
                     end
                  end
                  mpq_pkg::MODE_DEQUEUE: begin
                     if (count_ff == '0) begin
                        status_in = mpq_pkg::STATUS_EMPTY;
                        state_in  = ST_FINISH;
                     end else begin
                        // The front index is the first maximum; move what
                        // follows it down.
                        rd_ptr_in = CNT_W'(front_idx_ff) + CNT_W'(1);
                        state_in  = ST_SHIFT;
                     end
                  end
                  mpq_pkg::MODE_MODIFY: begin
                     rd_ptr_in = '0;
                     state_in  = ST_SEARCH;
                  end
                  mpq_pkg::MODE_CLEAR: begin
                     count_in = '0;
                     state_in = ST_FINISH;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end

         ST_SEARCH: begin
            if (pvld_ff && (rd_val == val_ff)) begin
               // First match: rewrite its priority, then find the new front.
               wr_en     = 1'b1;
               wr_addr   = paddr_ff;
               wr_data   = {rd_val, key_ff};
               rd_ptr_in = '0;
               pvld_in   = 1'b0;
               state_in  = ST_SCAN;
            end else if (!issue && !pvld_ff) begin
               status_in = mpq_pkg::STATUS_NOT_FOUND;
               state_in  = ST_FINISH;
            end
         end

         ST_SHIFT: begin
            if (pvld_ff) begin
               wr_en   = 1'b1;
               wr_addr = paddr_ff - ADDR_W'(1);
               wr_data = rd_data;
            end
            if (!issue && !pvld_ff) begin
               count_in  = count_ff - CNT_W'(1);
               rd_ptr_in = '0;
               state_in  = (count_ff == CNT_W'(1)) ? ST_FINISH : ST_SCAN;
            end
         end

         ST_SCAN: begin
            if (pvld_ff && ((paddr_ff == '0) || (rd_prio > front_prio_ff))) begin
               front_idx_in  = paddr_ff;
               front_prio_in = rd_prio;
               front_val_in  = rd_val;
            end
            if (!issue && !pvld_ff) begin
               state_in = ST_FINISH;
            end
         end

         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               rsp_front_in  = (count_ff == '0) ? '0 : front_val_ff;
               rsp_empty_in  = (count_ff == '0);
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         pvld_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         pvld_ff      <= pvld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rd_ptr_ff     <= rd_ptr_in;
      paddr_ff      <= paddr_in;
      front_idx_ff  <= front_idx_in;
      front_prio_ff <= front_prio_in;
      front_val_ff  <= front_val_in;
      val_ff        <= val_in;
      key_ff        <= key_in;
      status_ff     <= status_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_front_ff  <= rsp_front_in;
      rsp_empty_ff  <= rsp_empty_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_count       = rsp_count_ff;
   assign rsp_front_value = rsp_front_ff;
   assign rsp_empty_res   = rsp_empty_ff;

endmodule

// File: verif/max_scan_priority_queue_tb.sv
// Self-checking testbench for the max-scan priority queue: a directed table
// and random traffic, checked against a behavioral mirror of the queue.
// Depends on mpq_pkg and max_scan_priority_queue.
`timescale 1ns / 1ps

module max_scan_priority_queue_tb;

   localparam int CNT_W          = $clog2(mpq_pkg::CAPACITY + 1);
   localparam int HALF_PERIOD_NS = 6;
   localparam int RESET_CYCLES   = 7;
   // The slowest operation walks the whole queue about twice.
   localparam int DRAIN_CYCLES   = 2 * mpq_pkg::CAPACITY + 16;
   // Timeout: roughly 290 transactions, each with the longest request gap,
   // the longest response stall and a full double scan, then taken a few
   // times over.
   localparam longint CYCLE_LIMIT = 3_000_000;

   // One response transaction as the queue should report it.
   typedef struct packed {
      mpq_pkg::status_type    status;
      logic [CNT_W-1:0]       count;
      logic signed [31:0]     front;
      logic                   empty;
   } queue_answer_type;

   // One row of the directed table. Where typed is set, the answer column
   // is the expected response; otherwise the mirror supplies it.
   typedef struct packed {
      mpq_pkg::mode_type      mode;
      logic signed [31:0]     value;
      logic signed [15:0]     prio;
      logic                   typed;
      queue_answer_type       answer;
   } stimulus_row_type;

   localparam queue_answer_type NO_ANSWER = '{mpq_pkg::STATUS_DONE, CNT_W'(0), 32'sh0, 1'b0};

   localparam int DIRECTED_ROWS = 23;
   localparam stimulus_row_type DIRECTED [DIRECTED_ROWS] = '{
      // Everything on an empty queue right after reset.
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b1,
        '{mpq_pkg::STATUS_EMPTY, CNT_W'(0), 32'sh0, 1'b1}},
      '{mpq_pkg::MODE_MODIFY,  32'sh5, 16'sh1, 1'b1,
        '{mpq_pkg::STATUS_NOT_FOUND, CNT_W'(0), 32'sh0, 1'b1}},
      '{mpq_pkg::MODE_CLEAR,   32'sh0, 16'sh0, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(0), 32'sh0, 1'b1}},
      // Value and priority extremes; a tie keeps the earlier entry in front.
      '{mpq_pkg::MODE_ENQUEUE, 32'sh7fffffff, 16'sh8000, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(1), 32'sh7fffffff, 1'b0}},
      '{mpq_pkg::MODE_ENQUEUE, 32'sh80000000, 16'sh7fff, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(2), 32'sh80000000, 1'b0}},
      '{mpq_pkg::MODE_ENQUEUE, 32'sh0, 16'sh7fff, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(3), 32'sh80000000, 1'b0}},
      '{mpq_pkg::MODE_ENQUEUE, 32'shffffffff, 16'sh0, 1'b0, NO_ANSWER},
      // Raise the first entry to the top priority: it ties and wins by position.
      '{mpq_pkg::MODE_MODIFY,  32'sh7fffffff, 16'sh7fff, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_MODIFY,  32'sh3039, 16'sh1, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b0, NO_ANSWER},
      // Duplicate values: modify must hit the lowest position only.
      '{mpq_pkg::MODE_ENQUEUE, 32'sh0, 16'shffff, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_MODIFY,  32'sh0, 16'sh8000, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_DEQUEUE, 32'sh0, 16'sh0, 1'b1,
        '{mpq_pkg::STATUS_EMPTY, CNT_W'(0), 32'sh0, 1'b1}},
      // Clear keeps stale entries in the RAM; they must never be found again.
      '{mpq_pkg::MODE_ENQUEUE, 32'sh55555555, 16'sh5555, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_ENQUEUE, 32'shaaaaaaaa, 16'shaaaa, 1'b0, NO_ANSWER},
      '{mpq_pkg::MODE_CLEAR,   32'sh0, 16'sh0, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(0), 32'sh0, 1'b1}},
      '{mpq_pkg::MODE_MODIFY,  32'sh55555555, 16'sh0, 1'b1,
        '{mpq_pkg::STATUS_NOT_FOUND, CNT_W'(0), 32'sh0, 1'b1}},
      '{mpq_pkg::MODE_ENQUEUE, 32'sh1, 16'sh1, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(1), 32'sh1, 1'b0}},
      '{mpq_pkg::MODE_CLEAR,   32'sh0, 16'sh0, 1'b1,
        '{mpq_pkg::STATUS_DONE, CNT_W'(0), 32'sh0, 1'b1}}
   };

   logic                    clock             = 1'b0;
   logic                    reset             = 1'b1;
   logic                    req_valid         = 1'b0;
   logic                    req_stall;
   logic [1:0]              req_mode          = mpq_pkg::MODE_ENQUEUE;
   logic signed [31:0]      req_item_value    = '0;
   logic signed [15:0]      req_item_priority = '0;
   logic                    rsp_valid;
   logic                    rsp_stall         = 1'b0;
   logic [1:0]              rsp_status;
   logic [CNT_W-1:0]        rsp_count;
   logic signed [31:0]      rsp_front_value;
   logic                    rsp_empty_res;

   // Mirror of the queue contents, kept in insertion order like the RAM.
   logic signed [31:0]      mirror_value [mpq_pkg::CAPACITY];
   logic signed [15:0]      mirror_prio  [mpq_pkg::CAPACITY];
   int                      mirror_count  = 0;

   queue_answer_type        answers_due [$];
   int                      mismatch_count = 0;
   int                      answer_index   = 0;
   int                      req_calm       = 0;
   longint                  cycle_count    = 0;

   max_scan_priority_queue i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_mode          (req_mode),
      .req_item_value    (req_item_value),
      .req_item_priority (req_item_priority),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_count         (rsp_count),
      .rsp_front_value   (rsp_front_value),
      .rsp_empty_res     (rsp_empty_res)
   );

   always #HALF_PERIOD_NS clock = ~clock;

   // Every mismatch goes through here: one line is printed and it is counted.
   task automatic report_mismatch(string msg);
      mismatch_count++;
      $display("[%0t] mismatch: %s", $realtime, msg);
   endtask

   // Length of the next idle stretch, in cycles. Most are short, a few are
   // long, and now and then a calm period forces a run of back-to-back cycles.
   function automatic int gap_len(inout int calm);
      int r;
      if (calm > 0) begin
         calm--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         calm = $urandom_range(8, 40);
         return 0;
      end
      if (r < 45) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // Position of the first entry holding the highest priority.
   function automatic int front_slot();
      int best;
      best = 0;
      for (int i = 1; i < mirror_count; i++) begin
         if (mirror_prio[i] > mirror_prio[best]) best = i;
      end
      return best;
   endfunction

   // Applies one operation to the mirror and returns the response the queue
   // owes for it.
   function automatic queue_answer_type mirror_queue_op(mpq_pkg::mode_type m,
                                                        logic signed [31:0] v,
                                                        logic signed [15:0] p);
      queue_answer_type a;
      int at;
      a.status = mpq_pkg::STATUS_DONE;
      case (m)
         mpq_pkg::MODE_ENQUEUE: begin
            if (mirror_count >= mpq_pkg::CAPACITY) begin
               a.status = mpq_pkg::STATUS_FULL;
            end else begin
               mirror_value[mirror_count] = v;
               mirror_prio[mirror_count]  = p;
               mirror_count++;
            end
         end
         mpq_pkg::MODE_DEQUEUE: begin
            if (mirror_count == 0) begin
               a.status = mpq_pkg::STATUS_EMPTY;
            end else begin
               // Close the hole left by the removed entry.
               for (at = front_slot(); at + 1 < mirror_count; at++) begin
                  mirror_value[at] = mirror_value[at + 1];
                  mirror_prio[at]  = mirror_prio[at + 1];
               end
               mirror_count--;
            end
         end
         mpq_pkg::MODE_MODIFY: begin
            a.status = mpq_pkg::STATUS_NOT_FOUND;
            for (at = 0; at < mirror_count; at++) begin
               if (mirror_value[at] == v) begin
                  mirror_prio[at] = p;
                  a.status = mpq_pkg::STATUS_DONE;
                  break;
               end
            end
         end
         default: begin
            mirror_count = 0;
         end
      endcase
      a.count = CNT_W'(mirror_count);
      a.front = (mirror_count != 0) ? mirror_value[front_slot()] : '0;
      a.empty = (mirror_count == 0);
      return a;
   endfunction

   // Values mostly come from a small pool or from entries already held, so
   // that modify finds its target and duplicates are common; the rest are
   // extremes and full-width random words.
   function automatic logic signed [31:0] pick_value();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && mirror_count != 0) return mirror_value[$urandom_range(0, mirror_count - 1)];
      if (r < 65) return $urandom_range(0, 7) - 4;
      if (r < 72) return ($urandom_range(0, 1) != 0) ? 32'sh7fffffff : 32'sh80000000;
      return $urandom;
   endfunction

   // Small priorities give plenty of ties; extremes and random words cover
   // the full signed range.
   function automatic logic signed [15:0] pick_prio();
      int r;
      r = $urandom_range(0, 99);
      if (r < 40) return 16'($urandom_range(0, 6) - 3);
      if (r < 50) return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
      return 16'($urandom);
   endfunction

   // Presents one request transaction and waits until it is taken. Valid is
   // only lowered when a gap precedes the next request, so back-to-back
   // requests keep it high. The expectation is queued at the accepting edge.
   task automatic offer_request(mpq_pkg::mode_type m, logic signed [31:0] v,
                                logic signed [15:0] p, logic typed,
                                queue_answer_type fixed);
      int gap;
      queue_answer_type predicted;
      gap = gap_len(req_calm);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_mode          <= m;
      req_item_value    <= v;
      req_item_priority <= p;
      do @(posedge clock); while (req_stall);
      predicted = mirror_queue_op(m, v, p);
      answers_due.push_back(typed ? fixed : predicted);
   endtask

   // Random operation mix. Below twenty entries the queue tends to grow,
   // above it the mix favors dequeue, which keeps most scans short.
   task automatic offer_random_op();
      int r;
      mpq_pkg::mode_type m;
      r = $urandom_range(0, 99);
      if (r < 4) m = mpq_pkg::MODE_CLEAR;
      else if (r < ((mirror_count < 20) ? 50 : 28)) m = mpq_pkg::MODE_ENQUEUE;
      else if (r < 72) m = mpq_pkg::MODE_DEQUEUE;
      else m = mpq_pkg::MODE_MODIFY;
      offer_request(m, pick_value(), pick_prio(), 1'b0, NO_ANSWER);
   endtask

   // Response-side back-pressure: random stall stretches between single
   // cycles of readiness, with calm periods of no stall at all.
   initial begin : rsp_backpressure
      int hold;
      int calm;
      calm = 0;
      @(posedge clock);
      forever begin
         hold = gap_len(calm);
         if (hold == 0) begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end else begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // Response checker: every accepted response transaction must match the
   // oldest outstanding expectation, field by field.
   always @(posedge clock) begin : answer_check
      queue_answer_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            report_mismatch($sformatf("unexpected response %0d: status %0d count %0d front %h",
                                      answer_index, rsp_status, rsp_count, rsp_front_value));
         end else begin
            want = answers_due.pop_front();
            if (rsp_status !== want.status)
               report_mismatch($sformatf("response %0d status: got %0d, expected %0d",
                                         answer_index, rsp_status, want.status));
            if (rsp_count !== want.count)
               report_mismatch($sformatf("response %0d count: got %0d, expected %0d",
                                         answer_index, rsp_count, want.count));
            if (rsp_front_value !== want.front)
               report_mismatch($sformatf("response %0d front_value: got %h, expected %h",
                                         answer_index, rsp_front_value, want.front));
            if (rsp_empty_res !== want.empty)
               report_mismatch($sformatf("response %0d empty_res: got %0d, expected %0d",
                                         answer_index, rsp_empty_res, want.empty));
         end
         answer_index++;
      end
   end

   // Watchdog. Reaching the limit means a response never arrived or the
   // handshake hung.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("** max_scan_priority_queue: FAILED **");
         $finish;
      end
   end

   initial begin : stimulus
      logic signed [31:0] hunt;
      logic hit;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty-queue corner cases, extremes, ties, duplicate
      // values and the stale contents left behind by clear.
      for (int row = 0; row < DIRECTED_ROWS; row++) begin
         offer_request(DIRECTED[row].mode, DIRECTED[row].value, DIRECTED[row].prio,
                       DIRECTED[row].typed, DIRECTED[row].answer);
      end

      // Random traffic on a small queue.
      repeat (200) offer_random_op();

      // Modify that scans every held entry without a match.
      do begin
         hunt = $urandom;
         hit  = 1'b0;
         for (int k = 0; k < mirror_count; k++) begin
            if (mirror_value[k] == hunt) hit = 1'b1;
         end
      end while (hit);
      offer_request(mpq_pkg::MODE_MODIFY, hunt, pick_prio(), 1'b0, NO_ANSWER);
      // Modify aimed at the last position, raised to the top priority.
      if (mirror_count != 0) begin
         offer_request(mpq_pkg::MODE_MODIFY, mirror_value[mirror_count - 1], 16'sh7fff,
                       1'b0, NO_ANSWER);
      end
      offer_request(mpq_pkg::MODE_CLEAR, 32'sh0, 16'sh0, 1'b0, NO_ANSWER);

      // A second stretch of small-queue traffic after the clear.
      repeat (60) offer_random_op();
      req_valid <= 1'b0;

      // Wait for every outstanding response, then give the queue time to
      // show any response that it should not produce.
      while (answers_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0) begin
         $display("** max_scan_priority_queue: PASSED **");
      end else begin
         $display("** max_scan_priority_queue: FAILED **");
      end
      $finish;
   end

endmodule
